### sv/semaphore_table_with_wait_queues_defines.svh
// assertion helpers for the semaphore table
`ifndef SEMAPHORE_TABLE_WITH_WAIT_QUEUES_DEFINES_SVH
`define SEMAPHORE_TABLE_WITH_WAIT_QUEUES_DEFINES_SVH

// plain property checked on every clock outside reset
`define STQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define STQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define STQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/stq_pkg.sv
`default_nettype none
package stq_pkg;

    // command codes
    localparam logic [2:0] CMD_OPEN    = 3'd0;
    localparam logic [2:0] CMD_WAIT    = 3'd1;
    localparam logic [2:0] CMD_POST    = 3'd2;
    localparam logic [2:0] CMD_CLOSE   = 3'd3;
    localparam logic [2:0] CMD_DESTROY = 3'd4;
    localparam logic [2:0] CMD_GETVAL  = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_SEM    = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_ATTACHED  = 3'd3;
    localparam logic [2:0] ST_SLOTS     = 3'd4;
    localparam logic [2:0] ST_TABLE     = 3'd5;
    localparam logic [2:0] ST_NOT_ATT   = 3'd6;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // write controls from the sequencer into the slot store
    typedef struct packed {
        logic pid_we;
        logic used_set;
        logic used_clr;
        logic row_clr;
        logic link_we;
    } t_slot_ctl;

endpackage
`default_nettype wire

### sv/semaphore_table_with_wait_queues.sv
`default_nettype none
// channel   direction  handshake                    payload
// command   in         i_in_valid / o_in_stall      i_command .. i_initial_value
// result    out        o_out_valid / i_out_stall    o_status .. o_waiting_count
//
// one word in, one word out; open walks the name store entry by entry and then the holder
// slots slot by slot, all serially through the compare unit, so the longest command is an open
// that finds its name in the last entry
// the input stalls until the sequencer is back in idle, which it enters as the result loads
// reset is synchronous, active low; it empties the table, no sweep is needed
// a stalled result holds its register; the next word is taken while it waits,
// and the sequencer parks at the end of that word until the register frees
module semaphore_table_with_wait_queues #(
    parameter int SEM_ENTRIES   = 16,
    parameter int SLOTS_PER_SEM = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_command,
    input  wire logic [15:0] i_caller_pid,
    input  wire logic [63:0] i_name_key,
    input  wire logic [3:0]  i_sem_index,
    input  wire logic [15:0] i_initial_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_status,
    output logic [3:0]       o_result_index,
    output logic             o_caller_blocks,
    output logic             o_wake_valid,
    output logic [15:0]      o_wake_pid,
    output logic [15:0]      o_count_value,
    output logic [3:0]       o_waiting_count
);
    `include "semaphore_table_with_wait_queues_defines.svh"

    localparam int EW = $clog2(SEM_ENTRIES);
    localparam int SW = $clog2(SLOTS_PER_SEM);
    localparam int LW = $clog2(SLOTS_PER_SEM + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_NRD   = 4'd2;
    localparam logic [3:0] S_NCMP  = 4'd3;
    localparam logic [3:0] S_OPNEW = 4'd4;
    localparam logic [3:0] S_OPMK  = 4'd5;
    localparam logic [3:0] S_HRD   = 4'd6;
    localparam logic [3:0] S_HCMP  = 4'd7;
    localparam logic [3:0] S_HDONE = 4'd8;
    localparam logic [3:0] S_QCHK  = 4'd9;
    localparam logic [3:0] S_QNXT  = 4'd10;
    localparam logic [3:0] S_QREM  = 4'd11;
    localparam logic [3:0] S_CLOSE = 4'd12;
    localparam logic [3:0] S_PRD   = 4'd13;
    localparam logic [3:0] S_PWAKE = 4'd14;
    localparam logic [3:0] S_FIN   = 4'd15;

    // entry table
    logic          r_valid [SEM_ENTRIES];
    logic [15:0]   r_count [SEM_ENTRIES];
    logic [LW-1:0] r_hold  [SEM_ENTRIES];
    logic [SW-1:0] r_head  [SEM_ENTRIES];
    logic [SW-1:0] r_tail  [SEM_ENTRIES];
    logic [LW-1:0] r_len   [SEM_ENTRIES];
    logic [63:0]   r_name_mem [SEM_ENTRIES];
    logic [63:0]   r_name_q;

    // sequencer
    logic [3:0]    r_state;
    logic [2:0]    r_cmd;
    logic [15:0]   r_pid;
    logic [63:0]   r_key;
    logic [3:0]    r_idx;
    logic [15:0]   r_init;
    logic [EW-1:0] r_e, r_free;
    logic          r_free_ok;
    logic [SW-1:0] r_s, r_h, r_sfree, r_cur, r_prev;
    logic          r_hfound, r_sfree_ok;
    logic [LW-1:0] r_k;
    logic [2:0]    r_status;
    logic [EW-1:0] r_res;
    logic          r_blocks, r_wv, r_report;
    logic [15:0]   r_wpid;

    // result register
    logic          r_ov;
    logic [2:0]    r_o_status;
    logic [3:0]    r_o_res;
    logic          r_o_blocks, r_o_wv;
    logic [15:0]   r_o_wpid, r_o_count;
    logic [3:0]    r_o_wcnt;

    stq_pkg::t_slot_ctl slot_ctl;
    logic [SW-1:0] rd_slot, lnk_rd_slot, wr_slot, lnk_wr_slot, lnk_wdata;
    logic [15:0]   pid_q;
    logic [SW-1:0] link_q;
    logic          used_bit;
    logic          cmp_en, cmp_eq;
    logic [63:0]   cmp_a, cmp_b;
    logic          accept, cmd_ok, fin_go;
    logic          c_attach, c_enq, c_relink, c_close_clr, c_destroy;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign fin_go     = !r_ov || !i_out_stall;

    // addressed entry exists and command is known
    assign cmd_ok = (r_cmd <= stq_pkg::CMD_GETVAL)
                 && ({28'd0, r_idx} < 32'(SEM_ENTRIES)) && r_valid[r_e];

    // slot store controls
    always_comb begin
        c_attach    = (r_state == S_HDONE) && (r_cmd == stq_pkg::CMD_OPEN)
                   && !r_hfound && r_sfree_ok;
        c_enq       = (r_state == S_QCHK) && (r_cmd == stq_pkg::CMD_WAIT) && (r_k == r_len[r_e]);
        c_relink    = (r_state == S_QREM) && (r_k != '0);
        c_close_clr = (r_state == S_CLOSE) && (r_hold[r_e] == LW'(1));
        c_destroy   = (r_state == S_DISP) && (r_cmd == stq_pkg::CMD_DESTROY) && cmd_ok;
        slot_ctl.pid_we   = (r_state == S_OPMK) || c_attach;
        slot_ctl.used_set = slot_ctl.pid_we;
        slot_ctl.used_clr = (r_state == S_CLOSE);
        slot_ctl.row_clr  = (r_state == S_OPMK) || c_close_clr || c_destroy;
        slot_ctl.link_we  = (c_enq && (r_len[r_e] != '0)) || c_relink;
        wr_slot     = (r_state == S_OPMK) ? '0 : r_sfree;
        lnk_wr_slot = c_relink ? r_prev : r_tail[r_e];
        lnk_wdata   = c_relink ? link_q : r_h;
        rd_slot     = (r_state == S_PRD) ? r_head[r_e] : r_s;
        lnk_rd_slot = (r_state == S_PRD) ? r_head[r_e] : r_cur;
    end

    // compare unit operand select
    always_comb begin
        cmp_en = 1'b0;
        cmp_a  = '0;
        cmp_b  = '0;
        case (r_state)
            S_NCMP: begin
                cmp_en = r_valid[r_e];
                cmp_a  = r_name_q;
                cmp_b  = r_key;
            end
            S_HCMP: begin
                cmp_en = used_bit;
                cmp_a  = {48'd0, pid_q};
                cmp_b  = {48'd0, r_pid};
            end
            S_QCHK: begin
                cmp_en = 1'b1;
                cmp_a  = 64'(r_cur);
                cmp_b  = 64'(r_h);
            end
            default: begin
                cmp_en = 1'b0;
            end
        endcase
    end

    stq_cmp u_cmp (
        .i_en (cmp_en),
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_eq (cmp_eq)
    );

    stq_slots #(
        .E (SEM_ENTRIES),
        .S (SLOTS_PER_SEM)
    ) u_slots (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (slot_ctl),
        .i_ent         (r_e),
        .i_rd_slot     (rd_slot),
        .i_lnk_rd_slot (lnk_rd_slot),
        .i_wr_slot     (wr_slot),
        .i_wr_pid      (r_pid),
        .i_clr_slot    (r_h),
        .i_lnk_wr_slot (lnk_wr_slot),
        .i_lnk_wdata   (lnk_wdata),
        .o_pid_q       (pid_q),
        .o_link_q      (link_q),
        .o_used        (used_bit)
    );

    // name store
    always_ff @(posedge i_clk) begin
        if (r_state == S_OPMK) begin
            r_name_mem[r_e] <= r_key;
        end
        r_name_q <= r_name_mem[r_e];
    end

    // sequencer and entry table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_e     <= '0;
            for (int i = 0; i < SEM_ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
                r_hold[i]  <= '0;
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_len[i]   <= '0;
            end
        end else begin
            if (r_ov && !i_out_stall && (r_state != S_FIN)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd    <= i_command;
                        r_pid    <= i_caller_pid;
                        r_key    <= i_name_key;
                        r_idx    <= i_sem_index;
                        r_init   <= i_initial_value;
                        r_e      <= EW'(i_sem_index);
                        r_status <= stq_pkg::ST_OK;
                        r_res    <= '0;
                        r_blocks <= 1'b0;
                        r_wv     <= 1'b0;
                        r_wpid   <= '0;
                        r_report <= 1'b0;
                        r_state  <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_s        <= '0;
                    r_hfound   <= 1'b0;
                    r_sfree_ok <= 1'b0;
                    if (r_cmd == stq_pkg::CMD_OPEN) begin
                        if (r_key == 64'd0) begin
                            r_status <= stq_pkg::ST_EMPTY;
                            r_state  <= S_FIN;
                        end else begin
                            r_e       <= '0;
                            r_free_ok <= 1'b0;
                            r_state   <= S_NRD;
                        end
                    end else if (!cmd_ok) begin
                        r_status <= stq_pkg::ST_NO_SEM;
                        r_state  <= S_FIN;
                    end else begin
                        case (r_cmd)
                            stq_pkg::CMD_WAIT, stq_pkg::CMD_CLOSE: begin
                                r_state <= S_HRD;
                            end
                            stq_pkg::CMD_POST: begin
                                r_report <= 1'b1;
                                if (r_len[r_e] != '0) begin
                                    r_state <= S_PRD;
                                end else begin
                                    if (r_count[r_e] != stq_pkg::COUNT_MAX) begin
                                        r_count[r_e] <= r_count[r_e] + 16'd1;
                                    end
                                    r_state <= S_FIN;
                                end
                            end
                            stq_pkg::CMD_DESTROY: begin
                                r_valid[r_e] <= 1'b0;
                                r_hold[r_e]  <= '0;
                                r_head[r_e]  <= '0;
                                r_tail[r_e]  <= '0;
                                r_len[r_e]   <= '0;
                                r_state      <= S_FIN;
                            end
                            default: begin
                                r_report <= 1'b1;
                                r_state  <= S_FIN;
                            end
                        endcase
                    end
                end
                S_NRD: begin
                    r_state <= S_NCMP;
                end
                S_NCMP: begin
                    if (cmp_eq) begin
                        r_state <= S_HRD;
                    end else begin
                        if (!r_valid[r_e] && !r_free_ok) begin
                            r_free    <= r_e;
                            r_free_ok <= 1'b1;
                        end
                        if (r_e == EW'(SEM_ENTRIES - 1)) begin
                            r_state <= S_OPNEW;
                        end else begin
                            r_e     <= r_e + EW'(1);
                            r_state <= S_NRD;
                        end
                    end
                end
                S_OPNEW: begin
                    if (!r_free_ok) begin
                        r_status <= stq_pkg::ST_TABLE;
                        r_state  <= S_FIN;
                    end else begin
                        r_e     <= r_free;
                        r_state <= S_OPMK;
                    end
                end
                S_OPMK: begin
                    r_valid[r_e] <= 1'b1;
                    r_count[r_e] <= r_init;
                    r_hold[r_e]  <= LW'(1);
                    r_head[r_e]  <= '0;
                    r_tail[r_e]  <= '0;
                    r_len[r_e]   <= '0;
                    r_res        <= r_e;
                    r_report     <= 1'b1;
                    r_state      <= S_FIN;
                end
                S_HRD: begin
                    r_state <= S_HCMP;
                end
                S_HCMP: begin
                    if (cmp_eq && !r_hfound) begin
                        r_h      <= r_s;
                        r_hfound <= 1'b1;
                    end
                    if (!used_bit && !r_sfree_ok) begin
                        r_sfree    <= r_s;
                        r_sfree_ok <= 1'b1;
                    end
                    if (r_s == SW'(SLOTS_PER_SEM - 1)) begin
                        r_state <= S_HDONE;
                    end else begin
                        r_s     <= r_s + SW'(1);
                        r_state <= S_HRD;
                    end
                end
                S_HDONE: begin
                    r_cur  <= r_head[r_e];
                    r_prev <= '0;
                    r_k    <= '0;
                    if (r_cmd == stq_pkg::CMD_OPEN) begin
                        if (r_hfound) begin
                            r_status <= stq_pkg::ST_ATTACHED;
                        end else if (!r_sfree_ok) begin
                            r_status <= stq_pkg::ST_SLOTS;
                        end else begin
                            r_hold[r_e] <= r_hold[r_e] + LW'(1);
                            r_res       <= r_e;
                            r_report    <= 1'b1;
                        end
                        r_state <= S_FIN;
                    end else if (!r_hfound) begin
                        r_status <= stq_pkg::ST_NOT_ATT;
                        r_state  <= S_FIN;
                    end else if (r_cmd == stq_pkg::CMD_CLOSE) begin
                        r_state <= S_QCHK;
                    end else begin
                        r_report <= 1'b1;
                        if (r_count[r_e] != 16'd0) begin
                            r_count[r_e] <= r_count[r_e] - 16'd1;
                            r_state      <= S_FIN;
                        end else begin
                            r_blocks <= 1'b1;
                            r_state  <= S_QCHK;
                        end
                    end
                end
                S_QCHK: begin
                    if (r_k == r_len[r_e]) begin
                        if (r_cmd == stq_pkg::CMD_WAIT) begin
                            if (r_len[r_e] == '0) begin
                                r_head[r_e] <= r_h;
                            end
                            r_tail[r_e] <= r_h;
                            r_len[r_e]  <= r_len[r_e] + LW'(1);
                            r_state     <= S_FIN;
                        end else begin
                            r_state <= S_CLOSE;
                        end
                    end else if (cmp_eq) begin
                        r_state <= (r_cmd == stq_pkg::CMD_WAIT) ? S_FIN : S_QREM;
                    end else begin
                        r_state <= S_QNXT;
                    end
                end
                S_QNXT: begin
                    r_prev  <= r_cur;
                    r_cur   <= link_q;
                    r_k     <= r_k + LW'(1);
                    r_state <= S_QCHK;
                end
                S_QREM: begin
                    if (r_k == '0) begin
                        r_head[r_e] <= link_q;
                    end
                    if (r_k + LW'(1) == r_len[r_e]) begin
                        r_tail[r_e] <= r_prev;
                    end
                    r_len[r_e] <= r_len[r_e] - LW'(1);
                    r_state    <= S_CLOSE;
                end
                S_CLOSE: begin
                    if (c_close_clr) begin
                        r_valid[r_e] <= 1'b0;
                        r_hold[r_e]  <= '0;
                        r_head[r_e]  <= '0;
                        r_tail[r_e]  <= '0;
                        r_len[r_e]   <= '0;
                    end else begin
                        r_hold[r_e] <= r_hold[r_e] - LW'(1);
                        r_report    <= 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_PRD: begin
                    r_state <= S_PWAKE;
                end
                S_PWAKE: begin
                    r_wv        <= 1'b1;
                    r_wpid      <= pid_q;
                    r_head[r_e] <= link_q;
                    r_len[r_e]  <= r_len[r_e] - LW'(1);
                    r_state     <= S_FIN;
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_ov        <= 1'b1;
                        r_o_status  <= r_status;
                        r_o_res     <= 4'(r_res);
                        r_o_blocks  <= r_blocks;
                        r_o_wv      <= r_wv;
                        r_o_wpid    <= r_wpid;
                        r_o_count   <= r_report ? r_count[r_e] : 16'd0;
                        r_o_wcnt    <= r_report ? 4'(r_len[r_e]) : 4'd0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_ov;
    assign o_status        = r_o_status;
    assign o_result_index  = r_o_res;
    assign o_caller_blocks = r_o_blocks;
    assign o_wake_valid    = r_o_wv;
    assign o_wake_pid      = r_o_wpid;
    assign o_count_value   = r_o_count;
    assign o_waiting_count = r_o_wcnt;

    // a wake only ever dequeues from a non-empty queue
    `STQ_ASSERT_IMP(a_wake_nonempty, r_state == S_PWAKE, r_len[r_e] != '0, "wake on empty queue")
    // a finished word waits while the result register is held
    `STQ_ASSERT_NXT(a_fin_hold, r_state == S_FIN && r_ov && i_out_stall, r_state == S_FIN,
        "result overwritten while stalled")
    // queue never longer than the holder count of a live entry
    `STQ_ASSERT_IMP(a_queue_bound, r_valid[r_e], r_len[r_e] <= r_hold[r_e],
        "queue longer than holders")
endmodule
`default_nettype wire

### sv/stq_cmp.sv
`default_nettype none
// shared equality unit used by name, holder and queue searches
module stq_cmp (
    input  wire logic        i_en,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic             o_eq
);
    assign o_eq = i_en && (i_a == i_b);
endmodule
`default_nettype wire

### sv/stq_slots.sv
`default_nettype none
// holder slots of all entries: pid and link stores, used flags
module stq_slots #(
    parameter int E = 16,
    parameter int S = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire stq_pkg::t_slot_ctl    i_ctl,
    input  wire logic [$clog2(E)-1:0]  i_ent,
    input  wire logic [$clog2(S)-1:0]  i_rd_slot,
    input  wire logic [$clog2(S)-1:0]  i_lnk_rd_slot,
    input  wire logic [$clog2(S)-1:0]  i_wr_slot,
    input  wire logic [15:0]           i_wr_pid,
    input  wire logic [$clog2(S)-1:0]  i_clr_slot,
    input  wire logic [$clog2(S)-1:0]  i_lnk_wr_slot,
    input  wire logic [$clog2(S)-1:0]  i_lnk_wdata,
    output logic [15:0]                o_pid_q,
    output logic [$clog2(S)-1:0]       o_link_q,
    output logic                       o_used
);
    localparam int SW = $clog2(S);
    localparam int AW = $clog2(E * S);

    logic [15:0]   r_pid_mem [E*S];
    logic [SW-1:0] r_link_mem [E*S];
    logic [S-1:0]  r_used [E];
    logic [S-1:0]  n_used_row;
    logic [AW-1:0] rd_addr, lnk_rd_addr, wr_addr, lnk_wr_addr;

    // flat addresses within the current entry
    assign rd_addr     = AW'(i_ent) * AW'(S) + AW'(i_rd_slot);
    assign lnk_rd_addr = AW'(i_ent) * AW'(S) + AW'(i_lnk_rd_slot);
    assign wr_addr     = AW'(i_ent) * AW'(S) + AW'(i_wr_slot);
    assign lnk_wr_addr = AW'(i_ent) * AW'(S) + AW'(i_lnk_wr_slot);

    // pid store
    always_ff @(posedge i_clk) begin
        if (i_ctl.pid_we) begin
            r_pid_mem[wr_addr] <= i_wr_pid;
        end
        o_pid_q <= r_pid_mem[rd_addr];
    end

    // queue link store
    always_ff @(posedge i_clk) begin
        if (i_ctl.link_we) begin
            r_link_mem[lnk_wr_addr] <= i_lnk_wdata;
        end
        o_link_q <= r_link_mem[lnk_rd_addr];
    end

    // next used row of the current entry: row clear, slot clear, slot set
    always_comb begin
        n_used_row = r_used[i_ent];
        if (i_ctl.row_clr) begin
            n_used_row = '0;
        end
        if (i_ctl.used_clr) begin
            n_used_row[i_clr_slot] = 1'b0;
        end
        if (i_ctl.used_set) begin
            n_used_row[i_wr_slot] = 1'b1;
        end
    end

    // used flags, cleared by reset, row-wise or per slot, and set per slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < E; i++) begin
                r_used[i] <= '0;
            end
        end else begin
            if (i_ctl.row_clr || i_ctl.used_clr || i_ctl.used_set) begin
                r_used[i_ent] <= n_used_row;
            end
        end
    end

    assign o_used = r_used[i_ent][i_rd_slot];
endmodule
`default_nettype wire

### tb/tb_top.sv
module tb_top;
    localparam int NSEM  = 16;
    localparam int NSLOT = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_command;
    logic [15:0] i_caller_pid;
    logic [63:0] i_name_key;
    logic [3:0]  i_sem_index;
    logic [15:0] i_initial_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic [3:0]  o_result_index;
    logic        o_caller_blocks;
    logic        o_wake_valid;
    logic [15:0] o_wake_pid;
    logic [15:0] o_count_value;
    logic [3:0]  o_waiting_count;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  index;
        logic        blocks;
        logic        wake_valid;
        logic [15:0] wake_pid;
        logic [15:0] count;
        logic [3:0]  waiting;
    } t_reply;

    // semaphore table mirror and its expected replies
    class sem_table_sb;
        bit          valid [NSEM];
        logic [63:0] name [NSEM];
        logic [15:0] count [NSEM];
        int          holders [NSEM];
        bit          used [NSEM][NSLOT];
        logic [15:0] pid_of [NSEM][NSLOT];
        int          link [NSEM][NSLOT];
        int          head [NSEM];
        int          tail [NSEM];
        int          qlen [NSEM];
        t_reply      pending [$];
        int          errors;

        function void clear(int e);
            valid[e] = 0;
            holders[e] = 0;
            for (int s = 0; s < NSLOT; s++) used[e][s] = 0;
            head[e] = 0;
            tail[e] = 0;
            qlen[e] = 0;
        endfunction

        function new();
            errors = 0;
            for (int e = 0; e < NSEM; e++) begin
                name[e] = 0;
                count[e] = 0;
                for (int s = 0; s < NSLOT; s++) begin
                    pid_of[e][s] = 0;
                    link[e][s] = 0;
                end
                clear(e);
            end
        endfunction

        function int holder(int e, logic [15:0] p);
            for (int s = 0; s < NSLOT; s++)
                if (used[e][s] && pid_of[e][s] == p) return s;
            return -1;
        endfunction

        // walk the wait chain; optionally unlink slot s
        function bit dequeue_slot(int e, int s, bit remove);
            int cur;
            int prev;
            cur = head[e];
            prev = 0;
            for (int k = 0; k < qlen[e]; k++) begin
                if (cur == s) begin
                    if (!remove) return 1;
                    if (k == 0) head[e] = link[e][cur];
                    else link[e][prev] = link[e][cur];
                    if (k + 1 == qlen[e]) tail[e] = prev;
                    qlen[e]--;
                    return 1;
                end
                prev = cur;
                cur = link[e][cur];
            end
            return 0;
        endfunction

        function void note_command(logic [2:0] cmd, logic [15:0] p, logic [63:0] key,
                                   logic [3:0] idx, logic [15:0] init);
            t_reply r;
            bit     rep;
            int     e;
            int     h;
            int     s;
            int     found;
            r = '0;
            rep = 0;
            e = idx;
            if (cmd == stq_pkg::CMD_OPEN) begin
                if (key == 0) r.status = stq_pkg::ST_EMPTY;
                else begin
                    found = -1;
                    for (int i = 0; i < NSEM; i++)
                        if (found < 0 && valid[i] && name[i] == key) found = i;
                    if (found >= 0) begin
                        e = found;
                        if (holder(e, p) >= 0) r.status = stq_pkg::ST_ATTACHED;
                        else begin
                            s = -1;
                            for (int i = NSLOT - 1; i >= 0; i--) if (!used[e][i]) s = i;
                            if (s < 0) r.status = stq_pkg::ST_SLOTS;
                            else begin
                                used[e][s] = 1;
                                pid_of[e][s] = p;
                                holders[e]++;
                                r.index = 4'(e);
                                rep = 1;
                            end
                        end
                    end else begin
                        e = -1;
                        for (int i = NSEM - 1; i >= 0; i--) if (!valid[i]) e = i;
                        if (e < 0) begin
                            r.status = stq_pkg::ST_TABLE;
                            e = 0;
                        end else begin
                            clear(e);
                            valid[e] = 1;
                            name[e] = key;
                            count[e] = init;
                            holders[e] = 1;
                            used[e][0] = 1;
                            pid_of[e][0] = p;
                            r.index = 4'(e);
                            rep = 1;
                        end
                    end
                end
            end else if (cmd > stq_pkg::CMD_GETVAL || !valid[e]) begin
                r.status = stq_pkg::ST_NO_SEM;
            end else if (cmd == stq_pkg::CMD_WAIT) begin
                h = holder(e, p);
                if (h < 0) r.status = stq_pkg::ST_NOT_ATT;
                else begin
                    rep = 1;
                    if (count[e] != 0) count[e]--;
                    else begin
                        r.blocks = 1;
                        if (!dequeue_slot(e, h, 0)) begin
                            if (qlen[e] == 0) head[e] = h;
                            else link[e][tail[e]] = h;
                            tail[e] = h;
                            qlen[e]++;
                        end
                    end
                end
            end else if (cmd == stq_pkg::CMD_POST) begin
                rep = 1;
                if (qlen[e] > 0) begin
                    s = head[e];
                    r.wake_valid = 1;
                    r.wake_pid = pid_of[e][s];
                    head[e] = link[e][s];
                    qlen[e]--;
                end else if (count[e] != stq_pkg::COUNT_MAX) count[e]++;
            end else if (cmd == stq_pkg::CMD_CLOSE) begin
                h = holder(e, p);
                if (h < 0) r.status = stq_pkg::ST_NOT_ATT;
                else begin
                    void'(dequeue_slot(e, h, 1));
                    used[e][h] = 0;
                    holders[e]--;
                    if (holders[e] == 0) clear(e);
                    else rep = 1;
                end
            end else if (cmd == stq_pkg::CMD_DESTROY) begin
                clear(e);
            end else begin
                rep = 1;
            end
            if (rep) begin
                r.count = count[e];
                r.waiting = 4'(qlen[e]);
            end
            pending.push_back(r);
        endfunction

        function void check_reply(t_reply got);
            t_reply x;
            if (pending.size() == 0) begin
                $error("result word with no command pending");
                errors++;
                return;
            end
            x = pending.pop_front();
            if (got.status !== x.status) begin
                $error("status exp %0d got %0d", x.status, got.status); errors++;
            end
            if (got.index !== x.index) begin
                $error("result_index exp %0d got %0d", x.index, got.index); errors++;
            end
            if (got.blocks !== x.blocks) begin
                $error("caller_blocks exp %0d got %0d", x.blocks, got.blocks); errors++;
            end
            if (got.wake_valid !== x.wake_valid) begin
                $error("wake_valid exp %0d got %0d", x.wake_valid, got.wake_valid);
                errors++;
            end
            if (got.wake_pid !== x.wake_pid) begin
                $error("wake_pid exp %0d got %0d", x.wake_pid, got.wake_pid); errors++;
            end
            if (got.count !== x.count) begin
                $error("count_value exp %0d got %0d", x.count, got.count); errors++;
            end
            if (got.waiting !== x.waiting) begin
                $error("waiting_count exp %0d got %0d", x.waiting, got.waiting); errors++;
            end
        endfunction
    endclass

    sem_table_sb sb;
    int          send_idle_pct;
    int          stall_pct;
    logic [63:0] names [6];
    logic [15:0] pids [6];

    semaphore_table_with_wait_queues u_dut (.*);

    // clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // result side: sample at rising edge, stall at falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_reply({o_status, o_result_index, o_caller_blocks, o_wake_valid,
                            o_wake_pid, o_count_value, o_waiting_count});
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // send one command word, honoring the idle rate; valid drops only while idle
    task automatic send_word(logic [2:0] cmd, logic [15:0] p, logic [63:0] key,
                             logic [3:0] idx, logic [15:0] init);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_caller_pid <= p;
        i_name_key <= key;
        i_sem_index <= idx;
        i_initial_value <= init;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_command(cmd, p, key, idx, init);
        @(negedge i_clk);
    endtask

    // random command biased toward a small set of names and pids
    task automatic send_random();
        logic [2:0]  cmd;
        logic [15:0] p;
        logic [63:0] key;
        logic [3:0]  idx;
        logic [15:0] init;
        int          r;
        r = $urandom_range(99);
        if (r < 20) cmd = stq_pkg::CMD_OPEN;
        else if (r < 45) cmd = stq_pkg::CMD_WAIT;
        else if (r < 68) cmd = stq_pkg::CMD_POST;
        else if (r < 85) cmd = stq_pkg::CMD_CLOSE;
        else if (r < 89) cmd = stq_pkg::CMD_DESTROY;
        else if (r < 98) cmd = stq_pkg::CMD_GETVAL;
        else cmd = 3'($urandom_range(7));
        p = ($urandom_range(9) == 0) ? 16'($urandom) : pids[$urandom_range(5)];
        key = ($urandom_range(9) == 0) ? {$urandom, $urandom} : names[$urandom_range(5)];
        if ($urandom_range(29) == 0) key = 0;
        idx = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(5));
        init = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2));
        send_word(cmd, p, key, idx, init);
    endtask

    // stop sending and wait for all results
    task automatic drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
    endtask

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_command = '0;
        i_caller_pid = '0;
        i_name_key = '0;
        i_sem_index = '0;
        i_initial_value = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        for (int i = 0; i < 6; i++) begin
            names[i] = {$urandom, $urandom} | 64'h1;
            pids[i] = 16'($urandom_range(65535, 1));
        end
        names[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        pids[0] = 16'hFFFF;
        pids[1] = 16'h0001;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty name, extremes, saturation, queueing, close/destroy
        send_word(stq_pkg::CMD_OPEN, 16'h1, 64'h0, 4'd0, 16'd0);
        send_word(stq_pkg::CMD_OPEN, 16'hFFFF, names[0], 4'hF, 16'hFFFE);
        send_word(stq_pkg::CMD_OPEN, 16'hFFFF, names[0], 4'd0, 16'd0);
        send_word(stq_pkg::CMD_POST, 16'h0, 64'h0, 4'd0, 16'd0);
        send_word(stq_pkg::CMD_POST, 16'h0, 64'h0, 4'd0, 16'd0);
        send_word(stq_pkg::CMD_GETVAL, 16'h5, 64'h0, 4'd0, 16'd0);
        send_word(stq_pkg::CMD_WAIT, 16'h1234, 64'h0, 4'd0, 16'd0);
        send_word(stq_pkg::CMD_OPEN, 16'h1, 64'h1, 4'd0, 16'h0);
        send_word(stq_pkg::CMD_OPEN, 16'h2, 64'h1, 4'd0, 16'h0);
        send_word(stq_pkg::CMD_WAIT, 16'h1, 64'h0, 4'd1, 16'd0);
        send_word(stq_pkg::CMD_WAIT, 16'h1, 64'h0, 4'd1, 16'd0);
        send_word(stq_pkg::CMD_WAIT, 16'h2, 64'h0, 4'd1, 16'd0);
        send_word(stq_pkg::CMD_CLOSE, 16'h1, 64'h0, 4'd1, 16'd0);
        send_word(stq_pkg::CMD_POST, 16'h9, 64'h0, 4'd1, 16'd0);
        send_word(stq_pkg::CMD_POST, 16'h9, 64'h0, 4'd1, 16'd0);
        send_word(stq_pkg::CMD_GETVAL, 16'h9, 64'h0, 4'hF, 16'd0);
        send_word(3'd6, 16'h9, 64'h0, 4'd0, 16'd0);
        send_word(3'd7, 16'h9, 64'h0, 4'd0, 16'd0);
        send_word(stq_pkg::CMD_DESTROY, 16'h7, 64'h0, 4'd1, 16'd0);
        send_word(stq_pkg::CMD_CLOSE, 16'hFFFF, 64'h0, 4'd0, 16'd0);
        // fill the table, then slot overflow
        for (int i = 0; i < 17; i++)
            send_word(stq_pkg::CMD_OPEN, 16'(i + 1), 64'(100 + i), 4'd0, 16'(i));
        for (int i = 0; i < 9; i++)
            send_word(stq_pkg::CMD_OPEN, 16'(i + 50), 64'd100, 4'd0, 16'd0);
        for (int i = 0; i < 16; i++)
            send_word(stq_pkg::CMD_DESTROY, 16'h1, 64'h0, 4'(i), 16'd0);
        drain();

        // random phases with different idle mixes
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: begin send_idle_pct = 65; stall_pct = 0; end
                2: begin send_idle_pct = 0; stall_pct = 65; end
                3: begin send_idle_pct = 36; stall_pct = 36; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            for (int n = 0; n < 400; n++) send_random();
        end
        send_idle_pct = 0;
        stall_pct = 0;
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

### semaphore_table_with_wait_queues.f
+incdir+sv
sv/stq_pkg.sv
sv/stq_cmp.sv
sv/stq_slots.sv
sv/semaphore_table_with_wait_queues.sv
tb/tb_top.sv
